/* src/ifu_pkg.sv */
package ifu_pkg;

    // field and value sizes
    localparam int MAX_FIELD_WIDTH_DEF = 64;
    localparam int MAG_W               = 64;
    localparam int NDIG_MAX            = 22;  // octal digits of a 64-bit value
    localparam int DEC_DIGITS          = 20;  // decimal digits of a 64-bit value
    localparam int HEX_DIGITS          = 16;
    localparam int NDIG_W              = $clog2(NDIG_MAX + 1);
    localparam int IDX_W               = $clog2(NDIG_MAX);
    localparam int STEP_W              = $clog2(MAG_W);

    // radix codes
    localparam logic [1:0] RADIX_OCT = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // status from the digit generator
    typedef struct packed {
        logic              done;
        logic [NDIG_W-1:0] ndig;
    } t_dig_status;

    // one digit value to its ascii character
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0000, d};
        end
        return base + {4'b0000, d} - 8'd10;
    endfunction

endpackage

/* src/ifu_digit_gen.sv */
module ifu_digit_gen (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ifu_pkg::MAG_W-1:0] i_magnitude,
    input  logic [1:0]                i_radix_select,
    input  logic                      i_prec_zero,
    input  logic [ifu_pkg::IDX_W-1:0] i_rd_idx,
    output logic [3:0]                o_rd_digit,
    output ifu_pkg::t_dig_status      o_status
);

    typedef enum logic [1:0] {
        G_IDLE,
        G_DABBLE,
        G_SCAN
    } t_gen_state;

    localparam int NDIG = ifu_pkg::NDIG_MAX;

    t_gen_state                    r_state;
    logic [3:0]                    r_digits [NDIG];
    logic [3:0]                    n_digits [NDIG];
    logic [3:0]                    adj      [NDIG];
    logic [3:0]                    load_dig [NDIG];
    logic [ifu_pkg::MAG_W-1:0]     r_val;
    logic [ifu_pkg::STEP_W-1:0]    r_step;
    logic [ifu_pkg::IDX_W-1:0]     r_pos;
    logic                          r_prec_zero;
    ifu_pkg::t_dig_status          r_status;
    logic [ifu_pkg::IDX_W-1:0]     rd_addr;
    logic [3:0]                    rd_digit;
    logic [3*NDIG-1:0]             mag_oct;
    logic [4*NDIG-1:0]             mag_hex;

    // single read port, shared by the scan and the character output
    assign rd_addr    = (r_state == G_SCAN) ? r_pos : i_rd_idx;
    assign rd_digit   = r_digits[rd_addr];
    assign o_rd_digit = rd_digit;
    assign o_status   = r_status;

    assign mag_oct = (3*NDIG)'(i_magnitude);
    assign mag_hex = (4*NDIG)'(i_magnitude);

    // digit slices for octal and hex, shift-and-add-3 step for decimal
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (i_radix_select[1]) begin
                load_dig[k] = (k < ifu_pkg::HEX_DIGITS) ? mag_hex[4*k +: 4] : 4'd0;
            end else begin
                load_dig[k] = {1'b0, mag_oct[3*k +: 3]};
            end
            adj[k] = (r_digits[k] >= 4'd5) ? r_digits[k] + 4'd3 : r_digits[k];
        end
        for (int k = 0; k < NDIG; k++) begin
            case (r_state)
                G_IDLE: begin
                    if (i_start && i_radix_select == ifu_pkg::RADIX_DEC) begin
                        n_digits[k] = 4'd0;
                    end else if (i_start) begin
                        n_digits[k] = load_dig[k];
                    end else begin
                        n_digits[k] = r_digits[k];
                    end
                end
                G_DABBLE: begin
                    if (k >= ifu_pkg::DEC_DIGITS) begin
                        n_digits[k] = 4'd0;
                    end else if (k == 0) begin
                        n_digits[k] = {adj[k][2:0], r_val[ifu_pkg::MAG_W-1]};
                    end else begin
                        n_digits[k] = {adj[k][2:0], adj[k-1][3]};
                    end
                end
                default: begin
                    n_digits[k] = r_digits[k];
                end
            endcase
        end
    end

    // digit registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NDIG; k++) begin
            r_digits[k] <= n_digits[k];
        end
    end

    // sequencer: load or convert, then scan down for the leading digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= G_IDLE;
            r_status.done <= 1'b0;
        end else begin
            r_status.done <= 1'b0;
            case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_prec_zero <= i_prec_zero;
                        r_val       <= i_magnitude;
                        r_step      <= '0;
                        r_pos       <= ifu_pkg::IDX_W'(NDIG - 1);
                        if (i_radix_select == ifu_pkg::RADIX_DEC) begin
                            r_state <= G_DABBLE;
                        end else begin
                            r_state <= G_SCAN;
                        end
                    end
                end
                G_DABBLE: begin
                    r_val  <= r_val << 1;
                    r_step <= r_step + 1'b1;
                    if (r_step == ifu_pkg::STEP_W'(ifu_pkg::MAG_W - 1)) begin
                        r_pos   <= ifu_pkg::IDX_W'(NDIG - 1);
                        r_state <= G_SCAN;
                    end
                end
                G_SCAN: begin
                    if (rd_digit != 4'd0) begin
                        r_status.done <= 1'b1;
                        r_status.ndig <= ifu_pkg::NDIG_W'(r_pos) + 1'b1;
                        r_state       <= G_IDLE;
                    end else if (r_pos == '0) begin
                        // zero value: one digit, or none at precision zero
                        r_status.done <= 1'b1;
                        r_status.ndig <= r_prec_zero ? '0 : ifu_pkg::NDIG_W'(1);
                        r_state       <= G_IDLE;
                    end else begin
                        r_pos <= r_pos - 1'b1;
                    end
                end
                default: begin
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/integer_field_formatter_unit.sv */
// Integer field formatter: prints one integer as a printf-style ASCII field.
// Input channel (i_in_valid / o_in_ready) takes one request: magnitude, sign,
// radix, case, flags, width and precision. Output channel (o_out_valid /
// i_out_ready) returns the field one character per transfer, o_last marking
// the final one; a field with no characters gives one transfer with
// o_empty_field and o_last set.
// Steps per request: the accept cycle (octal and hex digits load here),
// a shift-and-add-3 pass over all 64 magnitude bits for decimal, a
// leading-digit scan down from the top digit, a hand-over of the digit
// count, a setup state, stepping over the field sections, and one
// character per cycle while the receiver accepts. o_in_ready is high only
// while the sequencer is idle, so one request is worked on at a time; the
// next may be taken while the final character still sits in the output
// register.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_out_valid. A stalled receiver holds the output register and the
// sequencer waits with it; no character is lost.
module integer_field_formatter_unit #(
    parameter int MAX_FIELD_WIDTH = ifu_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [ifu_pkg::MAG_W-1:0] i_magnitude,
    input  logic                      i_is_negative,
    input  logic [1:0]                i_radix_select,
    input  logic                      i_upper_hex,
    input  logic                      i_align_left,
    input  logic                      i_pad_zero,
    input  logic                      i_force_plus,
    input  logic                      i_space_sign,
    input  logic [6:0]                i_field_width,
    input  logic signed [6:0]         i_min_digits,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [7:0]                o_character,
    output logic                      o_empty_field,
    output logic                      o_last
);

    localparam int CW = $clog2(MAX_FIELD_WIDTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_PREP,
        S_EMPTY,
        S_LEAD,
        S_SIGN,
        S_ZPAD,
        S_PREC,
        S_DIG,
        S_TRAIL
    } t_state;

    t_state                     r_state;
    logic                       r_upper;
    logic                       r_left;
    logic                       r_zero_pad;
    logic                       r_has_prec;
    logic                       r_sign_on;
    logic [7:0]                 r_sign_char;
    logic [CW-1:0]              r_width;
    logic [CW-1:0]              r_prec;
    logic [ifu_pkg::NDIG_W-1:0] r_ndig;
    logic [CW-1:0]              r_pad;
    logic [CW-1:0]              r_zeros;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              r_remain;
    logic                       r_out_valid;
    logic [7:0]                 r_out_char;
    logic                       r_out_empty;
    logic                       r_out_last;

    logic                       in_accept;
    logic                       can_emit;
    logic                       emit;
    logic [CW-1:0]              width_sat;
    logic [5:0]                 prec_sat;
    logic                       prec_zero;
    logic [CW-1:0]              ndig_ext;
    logic [CW-1:0]              zeros;
    logic [CW-1:0]              len;
    logic [CW-1:0]              pad;
    logic [CW-1:0]              total;
    logic [CW-1:0]              lead_cnt;
    logic [CW-1:0]              cnt_m1;
    logic [7:0]                 ph_char;
    t_state                     ph_next;
    logic [CW-1:0]              ph_next_cnt;
    logic [3:0]                 rd_digit;
    ifu_pkg::t_dig_status       dig_status;

    assign in_accept = i_in_valid && o_in_ready;
    assign can_emit  = !r_out_valid || i_out_ready;

    // a character is loaded into the output register this cycle
    assign emit = can_emit && ((r_state == S_EMPTY) ||
                  ((r_cnt != '0) && (r_state == S_LEAD || r_state == S_SIGN ||
                                     r_state == S_ZPAD || r_state == S_PREC ||
                                     r_state == S_DIG  || r_state == S_TRAIL)));

    // saturate width and precision
    assign width_sat = (i_field_width > 7'(MAX_FIELD_WIDTH)) ? CW'(MAX_FIELD_WIDTH)
                                                              : i_field_width[CW-1:0];
    assign prec_sat  = (i_min_digits[5:0] > 6'(MAX_FIELD_WIDTH - 1)) ?
                       6'(MAX_FIELD_WIDTH - 1) : i_min_digits[5:0];
    assign prec_zero = !i_min_digits[6] && (i_min_digits[5:0] == 6'd0);

    ifu_digit_gen u_digit_gen (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (in_accept),
        .i_magnitude    (i_magnitude),
        .i_radix_select (i_radix_select),
        .i_prec_zero    (prec_zero),
        .i_rd_idx       (cnt_m1[ifu_pkg::IDX_W-1:0]),
        .o_rd_digit     (rd_digit),
        .o_status       (dig_status)
    );

    // field section lengths
    assign ndig_ext = CW'(r_ndig);
    assign zeros    = (r_has_prec && r_prec > ndig_ext) ? r_prec - ndig_ext : '0;
    assign len      = ndig_ext + zeros + CW'(r_sign_on);
    assign pad      = (r_width > len) ? r_width - len : '0;
    assign total    = pad + len;
    assign lead_cnt = (!r_left && !r_zero_pad) ? pad : '0;
    assign cnt_m1   = r_cnt - 1'b1;

    // character and following section for each output state
    always_comb begin
        case (r_state)
            S_LEAD: begin
                ph_char     = ifu_pkg::CHAR_SPACE;
                ph_next     = S_SIGN;
                ph_next_cnt = CW'(r_sign_on);
            end
            S_SIGN: begin
                ph_char     = r_sign_char;
                ph_next     = S_ZPAD;
                ph_next_cnt = (!r_left && r_zero_pad) ? r_pad : '0;
            end
            S_ZPAD: begin
                ph_char     = ifu_pkg::CHAR_ZERO;
                ph_next     = S_PREC;
                ph_next_cnt = r_zeros;
            end
            S_PREC: begin
                ph_char     = ifu_pkg::CHAR_ZERO;
                ph_next     = S_DIG;
                ph_next_cnt = ndig_ext;
            end
            S_DIG: begin
                ph_char     = ifu_pkg::digit_char(rd_digit, r_upper);
                ph_next     = S_TRAIL;
                ph_next_cnt = r_left ? r_pad : '0;
            end
            S_TRAIL: begin
                ph_char     = ifu_pkg::CHAR_SPACE;
                ph_next     = S_IDLE;
                ph_next_cnt = '0;
            end
            default: begin
                ph_char     = ifu_pkg::CHAR_SPACE;
                ph_next     = S_IDLE;
                ph_next_cnt = '0;
            end
        endcase
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_upper     <= i_upper_hex;
                        r_left      <= i_align_left;
                        r_zero_pad  <= i_pad_zero && i_min_digits[6];
                        r_has_prec  <= !i_min_digits[6];
                        r_prec      <= CW'(prec_sat);
                        r_width     <= width_sat;
                        r_sign_on   <= i_is_negative || i_force_plus || i_space_sign;
                        r_sign_char <= i_is_negative ? ifu_pkg::CHAR_MINUS :
                                       i_force_plus  ? ifu_pkg::CHAR_PLUS  :
                                                       ifu_pkg::CHAR_SPACE;
                        r_state     <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (dig_status.done) begin
                        r_ndig  <= dig_status.ndig;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_pad    <= pad;
                    r_zeros  <= zeros;
                    r_remain <= total;
                    r_cnt    <= lead_cnt;
                    r_state  <= (total == '0) ? S_EMPTY : S_LEAD;
                end
                S_EMPTY: begin
                    if (can_emit) begin
                        r_out_char  <= ifu_pkg::CHAR_NUL;
                        r_out_empty <= 1'b1;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_LEAD, S_SIGN, S_ZPAD, S_PREC, S_DIG, S_TRAIL: begin
                    if (r_cnt == '0) begin
                        r_state <= ph_next;
                        r_cnt   <= ph_next_cnt;
                    end else if (can_emit) begin
                        r_out_char  <= ph_char;
                        r_out_empty <= 1'b0;
                        r_out_last  <= (r_remain == CW'(1));
                        r_cnt       <= cnt_m1;
                        r_remain    <= r_remain - 1'b1;
                        if (r_remain == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_character   = r_out_char;
    assign o_empty_field = r_out_empty;
    assign o_last        = r_out_last;

endmodule

/* src/ifu_checker.sv */
module ifu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_character,
    input logic       o_empty_field,
    input logic       o_last
);

    // a stalled character holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_character) && $stable(o_last)
             && $stable(o_empty_field)))
        else $error("stalled output changed");

    // an empty field is always the final transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_empty_field) |-> o_last)
        else $error("empty field without last");

    // busy right after taking a request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");

    // no new character in the cycle after a request is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("output started too early");

endmodule

bind integer_field_formatter_unit ifu_checker u_ifu_checker (.*);
